// ----- hw/rtl/csm_pkg.sv -----
// Package for the contiguous subsequence matcher.
// Holds sizes, operation codes and the controller-to-datapath command type.
// No dependencies.
package csm_pkg;

  // Pattern capacity and derived widths
  localparam int unsigned MaxPattern = 16;
  localparam int unsigned IdxW       = $clog2(MaxPattern);
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);
  localparam int unsigned WordW      = 32;

  // Operation codes carried on the input channel
  localparam logic OpPattern = 1'b0;
  localparam logic OpText    = 1'b1;

  // Commands from the controller, valid for one cycle each
  typedef struct packed {
    logic new_pattern;  // pattern beat that opens a fresh pattern
    logic load;         // pattern beat: store word, clear search
    logic search;       // text beat: advance the match vector
    logic finish;       // text beat with last: capture result, clear search
  } cmd_t;

endpackage

// ----- hw/rtl/csm_in_if.sv -----
// Input channel of the matcher: valid/ready plus one element beat.
// Depends on nothing.
interface csm_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output operation, output value, output last, input ready);
  modport sink   (input valid, input operation, input value, input last, output ready);
endinterface

// ----- hw/rtl/csm_out_if.sv -----
// Output channel of the matcher: valid/ready plus one result beat.
// Depends on nothing.
interface csm_out_if;
  logic valid;
  logic ready;
  logic found;
  logic pattern_overflow;

  modport source (output valid, output found, output pattern_overflow, input ready);
  modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

// ----- hw/rtl/contiguous_subsequence_match.sv -----
// Contiguous subsequence matcher, top level. Uses csm_pkg, csm_in_if,
// csm_out_if, csm_ctrl and csm_dp.
// The result of a text beat with last is registered, shown the cycle after it.
// Throughput: one beat per cycle; all pattern cells compare in parallel,
// and a waiting result blocks input only while not taken.
// Reset: asynchronous, active low; empty complete pattern, no result pending.
module contiguous_subsequence_match (
  input logic   clk_i,
  input logic   rst_ni,
  csm_in_if.sink    in_i,
  csm_out_if.source out_o
);
  import csm_pkg::*;

  cmd_t cmd;

  csm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  csm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (in_i.value),
    .found_o    (out_o.found),
    .overflow_o (out_o.pattern_overflow)
  );

endmodule

// ----- hw/rtl/csm_ctrl.sv -----
// Controller of the matcher: pattern open/closed state, handshakes, commands.
// Depends on csm_pkg.
module csm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output csm_pkg::cmd_t cmd_o
);
  import csm_pkg::*;

  typedef enum logic [1:0] {
    ST_OPEN   = 2'b01,  // pattern being loaded
    ST_CLOSED = 2'b10   // pattern complete (empty after reset)
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   is_text;

  // Take a beat whenever the result register is free or drains this cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign is_text     = (in_op_i == OpText);
  assign out_valid_o = out_valid_q;

  // Commands to the datapath
  always_comb begin
    cmd_o.load        = accept && !is_text;
    cmd_o.new_pattern = accept && !is_text && (state_q == ST_CLOSED);
    cmd_o.search      = accept && is_text;
    cmd_o.finish      = accept && is_text && in_last_i;
  end

  // Pattern state: a text beat always closes the pattern, as does a pattern beat with last
  always_comb begin
    state_d = state_q;
    if (accept) begin
      if (is_text || in_last_i) begin
        state_d = ST_CLOSED;
      end else begin
        state_d = ST_OPEN;
      end
    end
  end

  // Result valid: set on end of text, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLOSED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/csm_dp.sv -----
// Datapath of the matcher: pattern store, per-cell comparators, match vector,
// found/overflow flags and the result register. Depends on csm_pkg.
module csm_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csm_pkg::cmd_t      cmd_i,
  input  logic signed [31:0] value_i,
  output logic               found_o,
  output logic               overflow_o
);
  import csm_pkg::*;

  logic [WordW-1:0]      store_q [MaxPattern];
  logic [LenW-1:0]       len_q, len_d;
  logic                  ovf_q, ovf_d;
  logic [MaxPattern-1:0] pm_q, pm_d;
  logic                  found_q, found_d;
  logic [MaxPattern-1:0] pm_next;
  logic [LenW-1:0]       base_len;
  logic                  base_ovf;
  logic                  room;
  logic                  tail_hit;
  logic [IdxW-1:0]       tail_idx;
  logic                  found_now;
  logic                  res_found_q;
  logic                  res_ovf_q;

  // Length before this beat; a fresh pattern starts from zero
  assign base_len = cmd_i.new_pattern ? '0 : len_q;
  assign base_ovf = cmd_i.new_pattern ? 1'b0 : ovf_q;
  assign room     = (base_len < LenW'(MaxPattern));

  // One comparator per cell, gated by the prefix bit of the previous cell
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      pm_next[i] = (LenW'(i) < len_q) && (store_q[i] == value_i) &&
                   ((i == 0) ? 1'b1 : pm_q[(i == 0) ? 0 : i - 1]);
    end
  end

  // Bit of the final pattern cell
  assign tail_idx  = IdxW'(len_q - LenW'(1));
  assign tail_hit  = (len_q != '0) && pm_next[tail_idx];
  assign found_now = found_q || tail_hit;

  // Next state of the search and pattern bookkeeping
  always_comb begin
    len_d   = len_q;
    ovf_d   = ovf_q;
    pm_d    = pm_q;
    found_d = found_q;
    if (cmd_i.load) begin
      pm_d    = '0;
      found_d = 1'b0;
      len_d   = room ? base_len + LenW'(1) : base_len;
      ovf_d   = room ? base_ovf : 1'b1;
    end else if (cmd_i.search) begin
      if (cmd_i.finish) begin
        pm_d    = '0;
        found_d = 1'b0;
      end else begin
        pm_d    = pm_next;
        found_d = found_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      pm_q    <= '0;
      found_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      pm_q    <= pm_d;
      found_q <= found_d;
    end
  end

  // Pattern store: one write port, cells read in place
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      store_q[base_len[IdxW-1:0]] <= value_i;
    end
  end

  // Result register; an empty pattern always matches
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_found_q <= found_now || (len_q == '0);
      res_ovf_q   <= ovf_q;
    end
  end

  assign found_o    = res_found_q;
  assign overflow_o = res_ovf_q;

endmodule

// ----- tb/tb_contiguous_subsequence_match.sv -----
// Self-checking testbench for contiguous_subsequence_match.
// Holds a scoreboard class with a match predictor, and tasks that drive pattern and text beats.
// Depends on csm_pkg, csm_in_if, csm_out_if and the matcher RTL.
module tb_contiguous_subsequence_match;
  timeunit 1ns;
  timeprecision 1ps;

  import csm_pkg::*;

  localparam int unsigned NumItems  = 1750;
  localparam int unsigned NumSymbols = 4;

  typedef struct packed {
    logic found;
    logic overflow;
  } match_result_t;

  // Predicts the matcher and checks its results in order
  class match_scoreboard;
    logic [WordW-1:0]      pat_words [MaxPattern];
    int unsigned           pat_len;
    bit                    pat_done;
    bit                    ovf;
    logic [MaxPattern-1:0] prefix_hits;
    bit                    hit;
    match_result_t         expected_q [$];
    int unsigned           n_errors;
    int unsigned           n_results;
    int unsigned           n_found;
    int unsigned           n_ovf;
    int unsigned           n_pattern_beats;
    int unsigned           n_text_beats;

    function new();
      pat_len         = 0;
      pat_done        = 1'b1;
      ovf             = 1'b0;
      prefix_hits     = '0;
      hit             = 1'b0;
      n_errors        = 0;
      n_results       = 0;
      n_found         = 0;
      n_ovf           = 0;
      n_pattern_beats = 0;
      n_text_beats    = 0;
    endfunction

    // Update the predicted state for one accepted input beat
    function void note_input(logic op, logic [WordW-1:0] word, logic lst);
      logic [MaxPattern-1:0] nxt;
      match_result_t         res;
      if (op == OpPattern) begin
        n_pattern_beats++;
        // a pattern beat after a closed pattern starts a fresh one
        if (pat_done) begin
          pat_len  = 0;
          ovf      = 1'b0;
          pat_done = 1'b0;
        end
        prefix_hits = '0;
        hit         = 1'b0;
        if (pat_len < MaxPattern) begin
          pat_words[pat_len] = word;
          pat_len++;
        end else begin
          ovf = 1'b1;
        end
        if (lst) pat_done = 1'b1;
      end else begin
        n_text_beats++;
        // text closes any open pattern at its present length
        pat_done = 1'b1;
        nxt      = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (((i == 0) ? 1'b1 : prefix_hits[i-1]) && pat_words[i] == word) nxt[i] = 1'b1;
        end
        prefix_hits = nxt;
        if (pat_len > 0 && prefix_hits[pat_len-1]) hit = 1'b1;
        if (lst) begin
          res.found    = hit || (pat_len == 0);
          res.overflow = ovf;
          expected_q.push_back(res);
          prefix_hits = '0;
          hit         = 1'b0;
        end
      end
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_result(logic found, logic overflow);
      match_result_t exp_r;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 200)
          $display("%0t: result with none expected: found=%b overflow=%b",
                   $time, found, overflow);
        return;
      end
      exp_r = expected_q.pop_front();
      n_results++;
      if (exp_r.found) n_found++;
      if (exp_r.overflow) n_ovf++;
      if (found !== exp_r.found) begin
        n_errors++;
        if (n_errors <= 200)
          $display("%0t: found mismatch: expected %b, actual %b", $time, exp_r.found, found);
      end
      if (overflow !== exp_r.overflow) begin
        n_errors++;
        if (n_errors <= 200)
          $display("%0t: pattern_overflow mismatch: expected %b, actual %b",
                   $time, exp_r.overflow, overflow);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  csm_in_if  in_if ();
  csm_out_if out_if ();

  contiguous_subsequence_match dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  match_scoreboard  sb;
  bit               no_idle;
  int unsigned      n_sent;
  logic [WordW-1:0] symbols [NumSymbols];
  logic [WordW-1:0] cur_pattern [$];

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout, matcher stopped making progress", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Monitor both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.operation, in_if.value, in_if.last);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.found, out_if.pattern_overflow);
    end
  end

  // Result sink: random stall before each beat
  initial begin
    int unsigned gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // Drive one input beat after a random gap; valid stays high into a back-to-back beat
  task automatic send_beat(input logic op, input logic [WordW-1:0] word, input logic lst);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= word;
    in_if.last      <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
  endtask

  // Pattern of plen words drawn from the current symbol set
  task automatic load_pattern(input int unsigned plen, input bit close);
    logic [WordW-1:0] word;
    cur_pattern.delete();
    for (int unsigned k = 0; k < plen; k++) begin
      word = symbols[$urandom_range(0, NumSymbols - 1)];
      if (k < MaxPattern) cur_pattern.push_back(word);
      send_beat(OpPattern, word, close && (k == plen - 1));
    end
  endtask

  // Text of random symbols, optionally with the stored pattern planted in it
  task automatic send_text(input int unsigned tlen, input bit embed, input bit close);
    logic [WordW-1:0] text_words [$];
    int unsigned      off;
    if (embed && tlen < cur_pattern.size()) tlen = cur_pattern.size();
    for (int unsigned k = 0; k < tlen; k++)
      text_words.push_back(symbols[$urandom_range(0, NumSymbols - 1)]);
    if (embed && cur_pattern.size() > 0) begin
      off = $urandom_range(0, tlen - cur_pattern.size());
      foreach (cur_pattern[k]) text_words[off + k] = cur_pattern[k];
    end
    foreach (text_words[k]) send_beat(OpText, text_words[k], close && (k == tlen - 1));
  endtask

  // Stimulus
  initial begin
    int unsigned kind;
    int unsigned plen;
    int unsigned drain;
    sb              = new();
    no_idle         = 1'b0;
    n_sent          = 0;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OpPattern;
    in_if.value     <= '0;
    in_if.last      <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern after reset matches any text
    send_beat(OpText, 32'h0000_0005, 1'b1);
    // two-word pattern at the value extremes, then a match
    send_beat(OpPattern, 32'h8000_0000, 1'b0);
    send_beat(OpPattern, 32'h7FFF_FFFF, 1'b1);
    send_beat(OpText, 32'h8000_0000, 1'b0);
    send_beat(OpText, 32'h7FFF_FFFF, 1'b1);
    // text shorter than the pattern
    send_beat(OpText, 32'h7FFF_FFFF, 1'b1);
    // open pattern closed by the first text beat
    send_beat(OpPattern, 32'h0000_0000, 1'b0);
    send_beat(OpText, 32'h0000_0000, 1'b1);
    // pattern beat in the middle of a text abandons that text
    send_beat(OpText, 32'hFFFF_FFFF, 1'b0);
    send_beat(OpPattern, 32'hFFFF_FFFF, 1'b1);
    send_beat(OpText, 32'hFFFF_FFFF, 1'b1);
    // one word past capacity raises overflow
    for (int unsigned k = 0; k <= MaxPattern; k++)
      send_beat(OpPattern, k, k == MaxPattern);
    send_beat(OpText, 32'h0000_0000, 1'b1);

    // Random sequences: mostly pattern then texts, some noise and broken framing
    while (n_sent < NumItems) begin
      if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
      for (int k = 0; k < NumSymbols; k++) symbols[k] = $urandom();
      kind = $urandom_range(0, 9);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxPattern - 2, MaxPattern + 2)
                                         : $urandom_range(1, 5);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6))
          send_beat(1'($urandom_range(0, 1)), $urandom(), $urandom_range(0, 2) == 0);
      end else begin
        // kind 1 leaves the pattern open so text closes it
        load_pattern(plen, kind != 1);
        repeat ($urandom_range(1, 4))
          send_text($urandom_range(1, 12), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 15) != 0);
      end
    end
    in_if.valid <= 1'b0;

    // Drain outstanding results
    drain = 0;
    while (sb.expected_q.size() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (4) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
      sb.n_errors++;
    end

    $display("Drove %0d pattern beats and %0d text beats.", sb.n_pattern_beats,
             sb.n_text_beats);
    $display("Checked %0d results: %0d matches, %0d with truncated pattern.", sb.n_results,
             sb.n_found, sb.n_ovf);
    if (sb.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/csm_pkg.sv
hw/rtl/csm_in_if.sv
hw/rtl/csm_out_if.sv
hw/rtl/csm_ctrl.sv
hw/rtl/csm_dp.sv
hw/rtl/contiguous_subsequence_match.sv
tb/tb_contiguous_subsequence_match.sv
